// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hw/rtl/nec_ir_pkg.sv =====
// Types, timing windows and key table of the NEC infrared pulse decoder.
`timescale 1ns / 1ps
`default_nettype none

package nec_ir_pkg;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LEAD_LOW  = 3'd1,
    ST_LEAD_HIGH = 3'd2,
    ST_BIT_LOW   = 3'd3,
    ST_BIT_HIGH  = 3'd4
  } status_e;

  localparam int unsigned PhaseW = 7;
  localparam int unsigned DurW   = 16;

  localparam logic [PhaseW-1:0] PhaseIdle     = 7'd0;
  localparam logic [PhaseW-1:0] PhaseLeadHigh = 7'd1;
  localparam logic [PhaseW-1:0] PhaseFirstBit = 7'd2;
  localparam logic [PhaseW-1:0] LastPhase     = 7'd65;

  localparam logic [DurW-1:0] LeadLowMin  = 16'd7833;
  localparam logic [DurW-1:0] LeadLowMax  = 16'd8755;
  localparam logic [DurW-1:0] LeadHighMin = 16'd3686;
  localparam logic [DurW-1:0] LeadHighMax = 16'd4608;
  localparam logic [DurW-1:0] MarkMin     = 16'd313;
  localparam logic [DurW-1:0] MarkMax     = 16'd718;
  localparam logic [DurW-1:0] ZeroMin     = 16'd313;
  localparam logic [DurW-1:0] ZeroMax     = 16'd715;
  localparam logic [DurW-1:0] OneMin      = 16'd1346;
  localparam logic [DurW-1:0] OneMax      = 16'd1750;

  typedef struct packed {
    logic       found;
    logic [7:0] code;
  } key_t;

  function automatic key_t key_lookup(input logic [7:0] cmd);
    key_t k;
    k.found = 1'b1;
    case (cmd)
      8'h45: k.code = 8'h00;
      8'h46: k.code = 8'h00;
      8'h47: k.code = 8'h00;
      8'h44: k.code = 8'h00;
      8'h40: k.code = 8'h25;
      8'h43: k.code = 8'h27;
      8'h07: k.code = 8'h00;
      8'h15: k.code = 8'h28;
      8'h09: k.code = 8'h26;
      8'h16: k.code = 8'h30;
      8'h19: k.code = 8'h1B;
      8'h0D: k.code = 8'h0D;
      8'h0C: k.code = 8'h31;
      8'h18: k.code = 8'h32;
      8'h5E: k.code = 8'h33;
      8'h08: k.code = 8'h34;
      8'h1C: k.code = 8'h35;
      8'h5A: k.code = 8'h36;
      8'h42: k.code = 8'h37;
      8'h52: k.code = 8'h38;
      8'h4A: k.code = 8'h39;
      default: begin
        k.found = 1'b0;
        k.code  = 8'h00;
      end
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/nec_ir_pulse_decoder.sv =====
// Top level of the NEC infrared pulse decoder.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per finished line
//   phase: pin_level_i (0 mark low, 1 space high) and duration_i in counts.
//   Output channel (out_valid_o/out_ready_i) carries one word per finished
//   frame or failed check: status_o, the four received bytes and the key
//   table lookup of the command byte. Phases that only advance the frame, and
//   high phases while idle, give no word.
//   Order: a word accepted into the input register is decoded from there,
//   and its result is loaded into the output register when the input
//   register advances; a stall on out_ready_i can hold it in between.
//   Throughput: one word per cycle while no stall holds a result word; the
//   range compares, the shift register update and the key ROM sit in one
//   stage between the input register and the output register.
//   Reset: idle, waiting for a lead low, frame shift register clear, no word
//   held in either register.
//   Stall: while out_valid_o waits on out_ready_i, the input register holds a
//   word only if it would produce a result; words that only advance the frame
//   keep flowing. in_ready_o drops once the input register is held.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module nec_ir_pulse_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        pin_level_i,
  input  wire logic [15:0] duration_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       address_o,
  output logic [7:0]       address_inverse_o,
  output logic [7:0]       command_o,
  output logic [7:0]       command_inverse_o,
  output logic             key_found_o,
  output logic [7:0]       key_code_o
);

  logic                              s1_valid_q;
  logic                              s1_level_q;
  logic [nec_ir_pkg::DurW-1:0]       s1_dur_q;

  logic [nec_ir_pkg::PhaseW-1:0]     phase_q, phase_d;
  logic [31:0]                       shift_q, shift_d;

  logic                              emit;
  nec_ir_pkg::status_e               status_d;
  logic [31:0]                       bytes_d;
  nec_ir_pkg::key_t                  key_d;
  logic                              advance;

  logic                              out_valid_q;
  nec_ir_pkg::status_e               status_q;
  logic [31:0]                       bytes_q;
  nec_ir_pkg::key_t                  key_q;

  logic                              lead_low_ok, lead_high_ok, mark_ok, zero_ok, one_ok;
  logic [31:0]                       shifted;

  assign lead_low_ok  = (s1_dur_q >= nec_ir_pkg::LeadLowMin) &&
                        (s1_dur_q <= nec_ir_pkg::LeadLowMax);
  assign lead_high_ok = (s1_dur_q >= nec_ir_pkg::LeadHighMin) &&
                        (s1_dur_q <= nec_ir_pkg::LeadHighMax);
  assign mark_ok      = (s1_dur_q >= nec_ir_pkg::MarkMin) &&
                        (s1_dur_q <= nec_ir_pkg::MarkMax);
  assign zero_ok      = (s1_dur_q >= nec_ir_pkg::ZeroMin) &&
                        (s1_dur_q <= nec_ir_pkg::ZeroMax);
  assign one_ok       = (s1_dur_q >= nec_ir_pkg::OneMin) &&
                        (s1_dur_q <= nec_ir_pkg::OneMax);
  assign shifted      = {one_ok, shift_q[31:1]};

  always_comb begin
    emit     = 1'b0;
    status_d = nec_ir_pkg::ST_OK;
    bytes_d  = '0;
    key_d    = '0;
    phase_d  = phase_q;
    shift_d  = shift_q;
    if (phase_q == nec_ir_pkg::PhaseIdle) begin
      if (!s1_level_q) begin
        if (lead_low_ok) begin
          phase_d = nec_ir_pkg::PhaseLeadHigh;
          shift_d = '0;
        end else begin
          emit     = 1'b1;
          status_d = nec_ir_pkg::ST_LEAD_LOW;
        end
      end
    end else if (phase_q == nec_ir_pkg::PhaseLeadHigh) begin
      if (s1_level_q && lead_high_ok) begin
        phase_d = nec_ir_pkg::PhaseFirstBit;
      end else begin
        emit     = 1'b1;
        status_d = nec_ir_pkg::ST_LEAD_HIGH;
      end
    end else if (phase_q > nec_ir_pkg::LastPhase) begin
      emit     = 1'b1;
      status_d = nec_ir_pkg::ST_LEAD_LOW;
    end else if (!phase_q[0]) begin
      if (!s1_level_q && mark_ok) begin
        phase_d = phase_q + 7'd1;
      end else begin
        emit     = 1'b1;
        status_d = nec_ir_pkg::ST_BIT_LOW;
      end
    end else begin
      if (s1_level_q && (zero_ok || one_ok)) begin
        if (phase_q < nec_ir_pkg::LastPhase) begin
          phase_d = phase_q + 7'd1;
          shift_d = shifted;
        end else begin
          emit     = 1'b1;
          status_d = nec_ir_pkg::ST_OK;
          bytes_d  = shifted;
          key_d    = nec_ir_pkg::key_lookup(shifted[23:16]);
        end
      end else begin
        emit     = 1'b1;
        status_d = nec_ir_pkg::ST_BIT_HIGH;
      end
    end
    if (emit) begin
      phase_d = nec_ir_pkg::PhaseIdle;
      shift_d = '0;
    end
  end

  assign advance    = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_level_q <= pin_level_i;
      s1_dur_q   <= duration_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nec_ir_pkg::PhaseIdle;
      shift_q <= '0;
    end else if (advance) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      status_q <= status_d;
      bytes_q  <= bytes_d;
      key_q    <= key_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = status_q;
  assign address_o         = bytes_q[7:0];
  assign address_inverse_o = bytes_q[15:8];
  assign command_o         = bytes_q[23:16];
  assign command_inverse_o = bytes_q[31:24];
  assign key_found_o       = key_q.found;
  assign key_code_o        = key_q.code;

  `ASSERT_RST(a_phase_range, phase_q <= nec_ir_pkg::LastPhase, "phase index out of range")
  `ASSERT_RST(a_idle_clear, phase_q == nec_ir_pkg::PhaseIdle |-> shift_q == '0,
              "frame shift not clear while idle")
  `ASSERT_RST(a_err_zero, out_valid_q && status_q != nec_ir_pkg::ST_OK |->
              bytes_q == '0 && key_q == '0, "error word carries frame data")
  `ASSERT_RST(a_out_source, !out_valid_q ##1 out_valid_q |-> $past(advance && emit),
              "output word without a decoded phase")
  `ASSERT_RST(a_result_resets, advance && emit |=> phase_q == nec_ir_pkg::PhaseIdle,
              "decoder not idle after a result")

endmodule

`default_nettype wire
